@@ rtl/ccs_pkg.sv @@
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, codes and helpers for the chord segmenter.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [1:0] MODE_X    = 2'd0;
    localparam logic [1:0] MODE_Y    = 2'd1;
    localparam logic [1:0] MODE_Z    = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [2:0] REG_CENTRE_X     = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y     = 3'd1;
    localparam logic [2:0] REG_VESSEL_RAD   = 3'd2;
    localparam logic [2:0] REG_KAPPA_BLOOD  = 3'd3;
    localparam logic [2:0] REG_KAPPA_TISSUE = 3'd4;
    localparam logic [2:0] REG_CELL_DX      = 3'd5;
    localparam logic [2:0] REG_CELL_DY      = 3'd6;

    localparam logic [1:0] KIND_MISS  = 2'd0;
    localparam logic [1:0] KIND_CHORD = 2'd1;
    localparam logic [1:0] KIND_ZIN   = 2'd2;
    localparam logic [1:0] KIND_ZOUT  = 2'd3;

    localparam logic [15:0] FRAC_LO = 16'd655;
    localparam logic [15:0] FRAC_HI = 16'd64881;

    typedef struct packed {
        logic [31:0] centre_x;
        logic [31:0] centre_y;
        logic [31:0] vessel_radius;
        logic [31:0] kappa_blood;
        logic [31:0] kappa_tissue;
        logic [31:0] cell_dx;
        logic [31:0] cell_dy;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_y;
        logic [63:0] rad2;   // r*r - d*d for a chord
    } t_job;

    function automatic logic [15:0] frac_clamp(input logic [15:0] q);
        logic [15:0] v;
        v = q;
        if (v < FRAC_LO) v = FRAC_LO;
        if (v > FRAC_HI) v = FRAC_HI;
        return v;
    endfunction

endpackage

@@ rtl/ccs_queue.sv @@
// ----------------------------------------------------------------------------
// ccs_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module ccs_queue #(
    parameter int WIDTH = 67,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule

@@ rtl/ccs_front.sv @@
// ----------------------------------------------------------------------------
// ccs_front
// Accepts lines, measures the across offset and classifies each line.
// ----------------------------------------------------------------------------
module ccs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ccs_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_mode,
    input  logic [7:0]    i_line_a,
    input  logic [7:0]    i_line_b,
    output logic          o_push,
    output ccs_pkg::t_job o_job,
    input  logic          i_q_full
);
    import ccs_pkg::*;

    logic        adv;
    logic        r1_valid, r2_valid, r3_valid;
    logic [1:0]  r1_mode, r2_mode, r3_mode;
    logic [39:0] r1_pa, r1_pb;
    logic [31:0] r2_da, r2_db;
    logic        r2_outa, r2_outb, r3_outa, r3_outb;
    logic [63:0] r3_sqa, r3_sqb, r3_r2;
    logic [39:0] c_across, da, db;
    logic        outside;

    // Whole pipe holds while the last stage waits on a full queue
    assign adv     = !r3_valid || !i_q_full;
    assign o_ready = adv;
    assign o_push  = r3_valid && !i_q_full;

    assign c_across = {8'd0, (r1_mode == MODE_X) ? i_cfg.centre_y : i_cfg.centre_x};
    assign da = (r1_pa > c_across) ? r1_pa - c_across : c_across - r1_pa;
    assign db = (r1_pb > {8'd0, i_cfg.centre_y}) ? r1_pb - {8'd0, i_cfg.centre_y}
                                                  : {8'd0, i_cfg.centre_y} - r1_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (adv) begin
            // drop the meaningless mode here
            r1_valid <= i_valid && (i_mode != MODE_NONE);
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_mode <= i_mode;
            r1_pa   <= 40'(i_line_a) * 40'((i_mode == MODE_X) ? i_cfg.cell_dy : i_cfg.cell_dx);
            r1_pb   <= 40'(i_line_b) * 40'(i_cfg.cell_dy);
            r2_mode <= r1_mode;
            r2_da   <= da[31:0];
            r2_db   <= db[31:0];
            r2_outa <= da > {8'd0, i_cfg.vessel_radius};
            r2_outb <= db > {8'd0, i_cfg.vessel_radius};
            r3_mode <= r2_mode;
            r3_outa <= r2_outa;
            r3_outb <= r2_outb;
            r3_sqa  <= 64'(r2_da) * 64'(r2_db & 32'd0 | r2_da);
            r3_sqb  <= 64'(r2_db) * 64'(r2_db);
            r3_r2   <= 64'(i_cfg.vessel_radius) * 64'(i_cfg.vessel_radius);
        end
    end

    assign outside = r3_outa || r3_outb || (r3_sqa > r3_r2) || (r3_sqb > r3_r2 - r3_sqa);

    always_comb begin
        o_job.is_y = (r3_mode == MODE_Y);
        o_job.rad2 = r3_r2 - r3_sqa;
        case (r3_mode)
            MODE_Z:  o_job.kind = outside ? KIND_ZOUT : KIND_ZIN;
            default: o_job.kind = r3_outa ? KIND_MISS : KIND_CHORD;
        endcase
    end
endmodule

@@ rtl/ccs_back.sv @@
// ----------------------------------------------------------------------------
// ccs_back
// Square root of the half chord, end-cell division and segment emission.
// ----------------------------------------------------------------------------
module ccs_back #(
    parameter int GRID_X = 256,
    parameter int GRID_Y = 256,
    parameter int GRID_Z = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ccs_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  ccs_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_segment_index,
    output logic [31:0]   o_segment_kappa,
    output logic [7:0]    o_boundary_cell,
    output logic [15:0]   o_boundary_fraction,
    output logic          o_last
);
    import ccs_pkg::*;

    localparam int GRID_MAX  = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int QW        = $clog2(GRID_MAX);
    localparam int DIV_STEPS = QW + 16;
    localparam int DCW       = $clog2(DIV_STEPS + 1);
    localparam logic [15:0] TOP_X = 16'(GRID_X - 1);
    localparam logic [15:0] TOP_Y = 16'(GRID_Y - 1);
    localparam logic [15:0] TOP_Z = 16'(GRID_Z - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_ENDS = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_TAIL = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [63:0] r_rem, n_rem, r_res, n_res, r_bit, n_bit;
    logic [31:0] r_c, n_c, r_sp, n_sp;
    logic [15:0] r_top, n_top;
    logic [44:0] r_gsp, n_gsp;
    logic [32:0] r_rend, n_rend;
    logic        r_bf, n_bf, r_hi, n_hi, r_clamp, n_clamp;
    logic [31:0] r_drem, n_drem;
    logic [DIV_STEPS-1:0] r_dsh, n_dsh, r_dq, n_dq;
    logic [DCW-1:0] r_dcnt, n_dcnt;

    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_oidx, n_oidx;
    logic [31:0] r_okap, n_okap;
    logic [7:0]  r_ocell, n_ocell;
    logic [15:0] r_ofrac, n_ofrac;
    logic        r_olast, n_olast;

    logic        can_emit;
    logic [63:0] trial;
    logic [33:0] lend;
    logic [32:0] dvt, dstart;
    logic        dge, dstart_go;
    logic [31:0] sp_raw;
    logic [15:0] seg_cell;

    assign can_emit = !r_ovalid || i_ready;
    assign trial    = r_res + r_bit;
    assign dvt      = {r_drem, r_dsh[DIV_STEPS-1]};
    assign dge      = dvt >= {1'b0, r_sp};
    assign lend     = {2'b00, r_c} - {2'b00, r_res[31:0]};
    assign seg_cell = r_clamp ? r_top : 16'(r_dq[DIV_STEPS-1:16]);
    assign sp_raw   = i_job.is_y ? i_cfg.cell_dy : i_cfg.cell_dx;

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_res    = r_res;
        n_bit    = r_bit;
        n_c      = r_c;
        n_sp     = r_sp;
        n_top    = r_top;
        n_gsp    = r_gsp;
        n_rend   = r_rend;
        n_bf     = r_bf;
        n_hi     = r_hi;
        n_clamp  = r_clamp;
        n_drem   = r_drem;
        n_dsh    = r_dsh;
        n_dq     = r_dq;
        n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid && !i_ready;
        n_oidx   = r_oidx;
        n_okap   = r_okap;
        n_ocell  = r_ocell;
        n_ofrac  = r_ofrac;
        n_olast  = r_olast;
        o_pop    = 1'b0;
        dstart   = '0;
        dstart_go = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_job.kind == KIND_CHORD) begin
                        o_pop   = 1'b1;
                        n_rem   = i_job.rad2;
                        n_res   = '0;
                        n_bit   = 64'd1 << 62;
                        n_c     = i_job.is_y ? i_cfg.centre_y : i_cfg.centre_x;
                        n_sp    = (sp_raw == '0) ? 32'd1 : sp_raw;
                        n_top   = i_job.is_y ? TOP_Y : TOP_X;
                        n_gsp   = 45'(i_job.is_y ? 13'(GRID_Y) : 13'(GRID_X))
                                  * 45'((sp_raw == '0) ? 32'd1 : sp_raw);
                        n_state = ST_SQRT;
                    end else if (can_emit) begin
                        o_pop    = 1'b1;
                        n_ovalid = 1'b1;
                        n_oidx   = 2'd0;
                        n_olast  = 1'b1;
                        case (i_job.kind)
                            KIND_MISS: begin
                                n_okap  = i_cfg.kappa_tissue;
                                n_ocell = i_job.is_y ? TOP_Y[7:0] : TOP_X[7:0];
                                n_ofrac = FRAC_LO;
                            end
                            KIND_ZIN: begin
                                n_okap  = i_cfg.kappa_blood;
                                n_ocell = TOP_Z[7:0];
                                n_ofrac = '0;
                            end
                            default: begin
                                n_okap  = i_cfg.kappa_tissue;
                                n_ocell = TOP_Z[7:0];
                                n_ofrac = '0;
                            end
                        endcase
                    end
                end
            end
            ST_SQRT: begin
                if (r_rem >= trial) begin
                    n_rem = r_rem - trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = ST_ENDS;
                end
            end
            ST_ENDS: begin
                n_rend = {1'b0, r_c} + {1'b0, r_res[31:0]};
                // chord starts before cell one: blood comes first
                n_bf = lend[33] || (lend[32:0] < {1'b0, r_sp});
                n_hi = n_bf;
                dstart = n_bf ? n_rend : lend[32:0];
                dstart_go = 1'b1;
            end
            ST_DIV: begin
                n_drem = dge ? 32'(dvt - {1'b0, r_sp}) : dvt[31:0];
                n_dsh  = r_dsh << 1;
                n_dq   = {r_dq[DIV_STEPS-2:0], dge};
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == DCW'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b0;
                    n_ocell  = seg_cell[7:0];
                    n_ofrac  = r_clamp ? FRAC_HI : frac_clamp(r_dq[15:0]);
                    if (r_hi) begin
                        n_oidx  = r_bf ? 2'd0 : 2'd1;
                        n_okap  = i_cfg.kappa_blood;
                        n_state = ST_TAIL;
                    end else begin
                        n_oidx    = 2'd0;
                        n_okap    = i_cfg.kappa_tissue;
                        n_hi      = 1'b1;
                        dstart    = r_rend;
                        dstart_go = 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_bf ? 2'd1 : 2'd2;
                    n_okap   = i_cfg.kappa_tissue;
                    n_ocell  = r_top[7:0];
                    n_ofrac  = FRAC_LO;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // load the divider; a quotient past the grid clamps to the last cell
        if (dstart_go) begin
            n_clamp = {12'd0, dstart} >= r_gsp;
            n_drem  = 32'(dstart >> QW);
            n_dsh   = {dstart[QW-1:0], 16'd0};
            n_dq    = '0;
            n_dcnt  = DCW'(DIV_STEPS);
            n_state = n_clamp ? ST_EMIT : ST_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_res   <= n_res;
        r_bit   <= n_bit;
        r_c     <= n_c;
        r_sp    <= n_sp;
        r_top   <= n_top;
        r_gsp   <= n_gsp;
        r_rend  <= n_rend;
        r_bf    <= n_bf;
        r_hi    <= n_hi;
        r_clamp <= n_clamp;
        r_drem  <= n_drem;
        r_dsh   <= n_dsh;
        r_dq    <= n_dq;
        r_dcnt  <= n_dcnt;
        r_oidx  <= n_oidx;
        r_okap  <= n_okap;
        r_ocell <= n_ocell;
        r_ofrac <= n_ofrac;
        r_olast <= n_olast;
    end

    assign o_valid             = r_ovalid;
    assign o_segment_index     = r_oidx;
    assign o_segment_kappa     = r_okap;
    assign o_boundary_cell     = r_ocell;
    assign o_boundary_fraction = r_ofrac;
    assign o_last              = r_olast;

    a_no_idx3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_oidx != 2'd3))
        else $error("segment index out of range");

    a_idx2_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_oidx == 2'd2)) |-> r_olast)
        else $error("third segment not marked last");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> ((r_ofrac >= FRAC_LO) && (r_ofrac <= FRAC_HI)))
        else $error("chord fraction outside clamp range");

    a_tail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_TAIL) && can_emit) |=> (r_state == ST_IDLE) && r_olast)
        else $error("tail segment did not close the line");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ((r_dcnt != '0) && (r_dcnt <= DCW'(DIV_STEPS))))
        else $error("divider step count out of range");
endmodule

@@ rtl/cylinder_chord_segmenter.sv @@
// ----------------------------------------------------------------------------
// cylinder_chord_segmenter
// Splits grid lines against a circular vessel section into kappa segments.
// ----------------------------------------------------------------------------
// Usage: lines enter on the input valid/ready channel (mode, line_a, line_b);
// segments leave on the output valid/ready channel, one per transaction, in
// order along the line, with last set on the final one. Registers are written
// through i_cfg_we/i_cfg_idx/i_cfg_wdata while the block is idle; the user must
// keep to that, as the block itself does not enforce it. Front part: three
// pipeline stages (products, offsets, squares), one line a cycle while the
// queue has room, feeding a four-entry queue. Back part: a line that misses
// the disk and a z-line each leave as one segment once the output register
// is free. A line that cuts the disk leaves the queue, runs a bit-serial
// square root, forms the chord ends, and runs a restoring division of
// log2(grid)+16 steps per end (the left end only when the chord starts past
// cell zero; none for an end that clamps to the last cell), then issues the
// closing tissue segment; that serial unit takes no new line until then and
// sets the throughput for chord lines. Reset empties the pipe and queue and
// loads the register reset values. A stalled receiver holds the output
// register; the queue then fills and the input ready falls.
// ----------------------------------------------------------------------------
module cylinder_chord_segmenter #(
    parameter int GRID_X = 256,
    parameter int GRID_Y = 256,
    parameter int GRID_Z = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_line_a,
    input  logic [7:0]  i_line_b,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_segment_index,
    output logic [31:0] o_segment_kappa,
    output logic [7:0]  o_boundary_cell,
    output logic [15:0] o_boundary_fraction,
    output logic        o_last
);
    import ccs_pkg::*;

    t_cfg r_cfg;
    t_job push_job, head_job;
    logic push, q_full, q_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_x      <= 32'd0;
            r_cfg.centre_y      <= 32'd0;
            r_cfg.vessel_radius <= 32'd0;
            r_cfg.kappa_blood   <= 32'd34079;
            r_cfg.kappa_tissue  <= 32'd32768;
            r_cfg.cell_dx       <= 32'd6554;
            r_cfg.cell_dy       <= 32'd6554;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTRE_X:     r_cfg.centre_x      <= i_cfg_wdata;
                REG_CENTRE_Y:     r_cfg.centre_y      <= i_cfg_wdata;
                REG_VESSEL_RAD:   r_cfg.vessel_radius <= i_cfg_wdata;
                REG_KAPPA_BLOOD:  r_cfg.kappa_blood   <= i_cfg_wdata;
                REG_KAPPA_TISSUE: r_cfg.kappa_tissue  <= i_cfg_wdata;
                REG_CELL_DX:      r_cfg.cell_dx       <= i_cfg_wdata;
                REG_CELL_DY:      r_cfg.cell_dy       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ccs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_mode   (i_mode),
        .i_line_a (i_line_a),
        .i_line_b (i_line_b),
        .o_push   (push),
        .o_job    (push_job),
        .i_q_full (q_full)
    );

    ccs_queue #(.WIDTH($bits(t_job)), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_job),
        .i_pop   (pop)
    );

    ccs_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_q_valid           (q_valid),
        .i_job               (head_job),
        .o_pop               (pop),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_segment_index     (o_segment_index),
        .o_segment_kappa     (o_segment_kappa),
        .o_boundary_cell     (o_boundary_cell),
        .o_boundary_fraction (o_boundary_fraction),
        .o_last              (o_last)
    );
endmodule

@@ tb/ccs_segment_checker.sv @@
// ----------------------------------------------------------------------------
// ccs_segment_checker
// Watches the line and segment channels of the chord segmenter, computes the
// segments each accepted line should produce and compares them in order.
// ----------------------------------------------------------------------------
module ccs_segment_checker #(
    parameter int GRID_X = 256,
    parameter int GRID_Y = 256,
    parameter int GRID_Z = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_line_a,
    input  logic [7:0]  i_line_b,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_segment_index,
    input  logic [31:0] i_segment_kappa,
    input  logic [7:0]  i_boundary_cell,
    input  logic [15:0] i_boundary_fraction,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import ccs_pkg::*;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] kappa;
        logic [7:0]  bcell;
        logic [15:0] frac;
        logic        last;
    } t_segment;

    t_segment    expected_segments[$];
    logic [31:0] cx, cy, rad, kb, kt, dx, dy;
    int          fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_segments.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] crossing_frac(input logic [63:0] off,
                                                  input logic [63:0] sp);
        logic [63:0] q;
        q = (off >= sp) ? 64'd65536 : (off << 16) / sp;
        if (q < 64'd655) q = 64'd655;
        if (q > 64'd64881) q = 64'd64881;
        return q[15:0];
    endfunction

    function automatic t_segment mk_seg(input logic [1:0] k, input logic [31:0] kap,
                                        input logic [63:0] bc, input logic [15:0] f,
                                        input logic l);
        t_segment s;
        s.index = k;
        s.kappa = kap;
        s.bcell = bc[7:0];
        s.frac  = f;
        s.last  = l;
        return s;
    endfunction

    task automatic push_chord(input logic [63:0] across, input logic [63:0] c_across,
                              input logic [63:0] c_along, input logic [63:0] sp_in,
                              input int grid);
        logic [63:0]        sp, top, d, r, h, hi, lo, right_end;
        logic signed [64:0] left_end;
        sp  = (sp_in == 0) ? 64'd1 : sp_in;
        top = 64'(grid - 1);
        d   = (across > c_across) ? across - c_across : c_across - across;
        r   = {32'd0, rad};
        if (d > r) begin
            expected_segments.push_back(mk_seg(2'd0, kt, top, FRAC_LO, 1'b1));
        end else begin
            h = int_sqrt(r * r - d * d);
            left_end  = $signed({1'b0, c_along}) - $signed({1'b0, h});
            right_end = c_along + h;
            hi = right_end / sp;
            if (hi > top) hi = top;
            if (left_end < $signed({1'b0, sp})) begin
                expected_segments.push_back(mk_seg(2'd0, kb, hi,
                    crossing_frac(right_end - hi * sp, sp), 1'b0));
                expected_segments.push_back(mk_seg(2'd1, kt, top, FRAC_LO, 1'b1));
            end else begin
                lo = left_end[63:0] / sp;
                if (lo > top) lo = top;
                expected_segments.push_back(mk_seg(2'd0, kt, lo,
                    crossing_frac(left_end[63:0] - lo * sp, sp), 1'b0));
                expected_segments.push_back(mk_seg(2'd1, kb, hi,
                    crossing_frac(right_end - hi * sp, sp), 1'b0));
                expected_segments.push_back(mk_seg(2'd2, kt, top, FRAC_LO, 1'b1));
            end
        end
    endtask

    task automatic predict_line(input logic [1:0] mode, input logic [7:0] a,
                                input logic [7:0] b);
        logic [63:0] dxo, dyo, r, r2, x2, y2;
        logic        outside;
        case (mode)
            MODE_X: push_chord(a * {32'd0, dy}, cy, cx, dx, GRID_X);
            MODE_Y: push_chord(a * {32'd0, dx}, cx, cy, dy, GRID_Y);
            MODE_Z: begin
                dxo = (a * {32'd0, dx} > cx) ? a * {32'd0, dx} - cx : cx - a * {32'd0, dx};
                dyo = (b * {32'd0, dy} > cy) ? b * {32'd0, dy} - cy : cy - b * {32'd0, dy};
                r   = {32'd0, rad};
                if (dxo > r || dyo > r) begin
                    outside = 1'b1;
                end else begin
                    r2 = r * r;
                    x2 = dxo * dxo;
                    y2 = dyo * dyo;
                    outside = (x2 > r2) || (y2 > r2 - x2);
                end
                expected_segments.push_back(mk_seg(2'd0, outside ? kt : kb,
                                                   64'(GRID_Z - 1), 16'd0, 1'b1));
            end
            default: ;  // drop: meaningless mode yields nothing
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_segment w;
        if (!i_rst_n) begin
            cx <= 0; cy <= 0; rad <= 0;
            kb <= 32'd34079; kt <= 32'd32768;
            dx <= 32'd6554; dy <= 32'd6554;
            expected_segments.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CENTRE_X:     cx  <= i_cfg_wdata;
                    REG_CENTRE_Y:     cy  <= i_cfg_wdata;
                    REG_VESSEL_RAD:   rad <= i_cfg_wdata;
                    REG_KAPPA_BLOOD:  kb  <= i_cfg_wdata;
                    REG_KAPPA_TISSUE: kt  <= i_cfg_wdata;
                    REG_CELL_DX:      dx  <= i_cfg_wdata;
                    REG_CELL_DY:      dy  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_line(i_mode, i_line_a, i_line_b);
            if (i_out_valid && i_out_ready) begin
                if (expected_segments.size() == 0) begin
                    report_mismatch("unexpected segment", 64'(i_segment_index), 64'd0);
                end else begin
                    w = expected_segments.pop_front();
                    if (i_segment_index !== w.index)
                        report_mismatch("segment_index", 64'(i_segment_index),
                                        64'(w.index));
                    if (i_segment_kappa !== w.kappa)
                        report_mismatch("segment_kappa", 64'(i_segment_kappa),
                                        64'(w.kappa));
                    if (i_boundary_cell !== w.bcell)
                        report_mismatch("boundary_cell", 64'(i_boundary_cell),
                                        64'(w.bcell));
                    if (i_boundary_fraction !== w.frac)
                        report_mismatch("boundary_fraction", 64'(i_boundary_fraction),
                                        64'(w.frac));
                    if (i_last !== w.last)
                        report_mismatch("last", 64'(i_last), 64'(w.last));
                end
            end
        end
    end

endmodule

@@ tb/tb_cylinder_chord_segmenter.sv @@
// ----------------------------------------------------------------------------
// tb_cylinder_chord_segmenter
// Drives grid lines under several vessel setups with random idle cycles on
// both channels; a checker beside the block predicts and compares segments.
// ----------------------------------------------------------------------------
module tb_cylinder_chord_segmenter;
    import ccs_pkg::*;

    localparam int LIMIT = 400000;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid, o_in_ready;
    logic [1:0]  i_mode;
    logic [7:0]  i_line_a, i_line_b;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_segment_index;
    logic [31:0] o_segment_kappa;
    logic [7:0]  o_boundary_cell;
    logic [15:0] o_boundary_fraction;
    logic        o_last;
    int          fail_count, pending;
    int          cycle_count = 0;
    logic        calm;   // stretch with no idling

    cylinder_chord_segmenter DUT (.*);

    ccs_segment_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid, .i_in_ready(o_in_ready), .i_mode, .i_line_a, .i_line_b,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_segment_index(o_segment_index), .i_segment_kappa(o_segment_kappa),
        .i_boundary_cell(o_boundary_cell), .i_boundary_fraction(o_boundary_fraction),
        .i_last(o_last), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_out_ready <= calm || ($urandom_range(99) >= 17);

    // leave the enable high across back-to-back writes; setup drops it
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic send_line(input logic [1:0] m, input logic [7:0] a, input logic [7:0] b);
        while (!calm && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_line_a   <= a;
        i_line_b   <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic setup(input logic [31:0] x, input logic [31:0] y, input logic [31:0] r,
                         input logic [31:0] kbl, input logic [31:0] kti,
                         input logic [31:0] sx, input logic [31:0] sy);
        write_reg(REG_CENTRE_X, x);
        write_reg(REG_CENTRE_Y, y);
        write_reg(REG_VESSEL_RAD, r);
        write_reg(REG_KAPPA_BLOOD, kbl);
        write_reg(REG_KAPPA_TISSUE, kti);
        write_reg(REG_CELL_DX, sx);
        write_reg(REG_CELL_DY, sy);
        i_cfg_we <= 1'b0;
    endtask

    // Random lines, mostly with line_a near near_a, which puts x-lines near the vessel
    task automatic random_lines(input int n, input int near_a);
        logic [1:0] m;
        int         a;
        repeat (n) begin
            m = $urandom_range(99) < 45 ? MODE_X :
                ($urandom_range(99) < 70 ? MODE_Y :
                 ($urandom_range(9) == 0 ? MODE_NONE : MODE_Z));
            a = $urandom_range(3) == 0 ? $urandom_range(255)
                                       : near_a + $urandom_range(40) - 20;
            if (a < 0) a = 0;
            if (a > 255) a = 255;
            send_line(m, a[7:0], $urandom_range(99) < 50 ? a[7:0] : 8'($urandom));
        end
    endtask

    initial begin
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_mode      = '0;
        i_line_a    = '0;
        i_line_b    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero radius
        send_line(MODE_X, 8'd0, 8'd0);
        send_line(MODE_Z, 8'd0, 8'd0);
        send_line(MODE_NONE, 8'd5, 8'd5);
        drain();

        // vessel at centre of a 0.1 grid
        setup(32'h000C_CCCC, 32'h000C_CCCC, 32'h0003_0000, 32'hFFFF_FFFF, 32'd0,
              32'd6554, 32'd6554);
        send_line(MODE_X, 8'd128, 8'd0);
        send_line(MODE_Y, 8'd128, 8'd255);
        send_line(MODE_X, 8'd98, 8'd7);
        send_line(MODE_Y, 8'd0, 8'd0);
        send_line(MODE_X, 8'd255, 8'd255);
        send_line(MODE_Z, 8'd128, 8'd128);
        send_line(MODE_Z, 8'd255, 8'd0);
        send_line(MODE_Z, 8'd0, 8'd255);
        send_line(MODE_NONE, 8'hAA, 8'h55);
        drain();

        // chord starting at cell 0 and running past the grid end
        setup(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1);
        send_line(MODE_X, 8'd0, 8'd1);
        send_line(MODE_Y, 8'd255, 8'd2);
        send_line(MODE_Z, 8'd255, 8'd255);
        send_line(MODE_X, 8'd1, 8'd3);
        drain();
        setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0010_0000, 32'd77, 32'd99,
              32'hFFFF_FFFF, 32'h0100_0000);
        send_line(MODE_X, 8'd255, 8'd0);
        send_line(MODE_Y, 8'd255, 8'd0);
        send_line(MODE_Z, 8'd255, 8'd255);
        drain();

        for (int p = 0; p < 6; p++) begin
            int          na;
            logic [31:0] sp;
            sp = $urandom_range(1000, 20000);
            na = $urandom_range(255);
            setup(sp * $urandom_range(255), na * sp, sp * $urandom_range(1, 60),
                  $urandom, $urandom, sp, (p == 3) ? 32'd0 : sp + $urandom_range(50));
            calm = (p == 2);
            random_lines(72, na);
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
